FILE: rtl/core/memo_delta_cache_macros.svh
// ----------------------------------------------------------------------------
// memo_delta_cache assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEMO_DELTA_CACHE_MACROS_SVH
`define MEMO_DELTA_CACHE_MACROS_SVH

// same-cycle implication
`define MDC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Request codes and register map of the memoization delta cache.
// ----------------------------------------------------------------------------
package mdc_pkg;

    // request kinds carried on the action field
    typedef enum logic [1:0] {
        ACT_KEY        = 2'd0,
        ACT_ACC_ENTRY  = 2'd1,
        ACT_ACC_RETURN = 2'd2
    } t_action;

    // configuration port
    localparam int   PADDR_W    = 3;
    localparam logic REG_ENABLE = 1'b0;

endpackage

FILE: rtl/core/mdc_ram.sv
// ----------------------------------------------------------------------------
// mdc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/memo_delta_cache.sv
// ----------------------------------------------------------------------------
// memo_delta_cache
// Single-entry memoization cache: key compare, delta replay on a hit,
// snapshot and delta capture around a missed routine call.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// request   in         start & !busy              i_action, i_word_index, i_word_value
// result    out        o_valid (one-cycle strobe) o_value_out, o_write_back, o_hit,
//                                                 o_hit_count, o_miss_count
// config    in/out     psel & penable & pwrite    paddr, pwdata / prdata
//
// One request per cycle; busy never rises. A request is captured in stage 1
// together with the store reads (registered RAM port), then the
// compare/add/subtract lands in the result register that strobes o_valid.
// Synchronous reset clears the control flags and counters and sets enable; the
// three stores are not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
module memo_delta_cache #(
    parameter int WORDS      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic [3:0]                  i_word_index,
    input  logic [31:0]                 i_word_value,
    // result
    output logic                        o_valid,
    output logic [31:0]                 o_value_out,
    output logic                        o_write_back,
    output logic                        o_hit,
    output logic [31:0]                 o_hit_count,
    output logic [31:0]                 o_miss_count,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    // configuration
    logic r_enable;
    logic cfg_wr;

    // stage 1: request register
    logic        accept;
    logic        r_s1_valid;
    logic [1:0]  r_s1_action;
    logic [3:0]  r_s1_idx;
    logic [31:0] r_s1_word;

    // control state
    logic        r_match, n_match;
    logic        r_entry_valid, n_entry_valid;
    logic        r_miss_pending, n_miss_pending;
    logic [31:0] r_hit_counter, n_hit_counter;
    logic [31:0] r_miss_counter, n_miss_counter;

    // result register
    logic        r_out_valid;
    logic [31:0] r_value_out, n_value_out;
    logic        r_write_back, n_write_back;
    logic        r_hit, n_hit;

    // stores
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] key_rdata, delta_rdata, snap_rdata;
    logic [WORD_WIDTH-1:0] key_rd, delta_rd, snap_rd;
    logic                  key_we, delta_we, snap_we;
    logic [WORD_WIDTH-1:0] word_w, delta_wdata;
    logic                  r_fwd_key, r_fwd_delta, r_fwd_snap;
    logic [WORD_WIDTH-1:0] r_fwd_key_data, r_fwd_delta_data, r_fwd_snap_data;

    logic                  in_range, is_first, is_last, active, key_eq;
    logic [WORD_WIDTH-1:0] value_w;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == mdc_pkg::REG_ENABLE) ? {31'b0, r_enable} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (cfg_wr && paddr[2] == mdc_pkg::REG_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end

    // stage 1 capture; the store reads are issued at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_action;
            r_s1_idx    <= i_word_index;
            r_s1_word   <= i_word_value;
        end
    end

    assign rd_addr = AW'(i_word_index);
    assign wr_addr = AW'(r_s1_idx);

    mdc_ram #(.WIDTH(WORD_WIDTH), .DEPTH(WORDS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (wr_addr),
        .i_wdata (word_w),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    mdc_ram #(.WIDTH(WORD_WIDTH), .DEPTH(WORDS)) u_delta_ram (
        .i_clk   (i_clk),
        .i_we    (delta_we),
        .i_waddr (wr_addr),
        .i_wdata (delta_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (delta_rdata)
    );

    mdc_ram #(.WIDTH(WORD_WIDTH), .DEPTH(WORDS)) u_snap_ram (
        .i_clk   (i_clk),
        .i_we    (snap_we),
        .i_waddr (wr_addr),
        .i_wdata (word_w),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (snap_rdata)
    );

    // a write landing on the entry being read returns old RAM data: forward it
    always_ff @(posedge i_clk) begin
        r_fwd_key        <= key_we && (wr_addr == rd_addr);
        r_fwd_delta      <= delta_we && (wr_addr == rd_addr);
        r_fwd_snap       <= snap_we && (wr_addr == rd_addr);
        r_fwd_key_data   <= word_w;
        r_fwd_delta_data <= delta_wdata;
        r_fwd_snap_data  <= word_w;
    end

    assign key_rd   = r_fwd_key   ? r_fwd_key_data   : key_rdata;
    assign delta_rd = r_fwd_delta ? r_fwd_delta_data : delta_rdata;
    assign snap_rd  = r_fwd_snap  ? r_fwd_snap_data  : snap_rdata;

    assign word_w      = WORD_WIDTH'(r_s1_word);
    assign delta_wdata = word_w - snap_rd;
    assign in_range    = 32'(r_s1_idx) < 32'(WORDS);
    assign is_first    = r_s1_idx == 4'd0;
    assign is_last     = 32'(r_s1_idx) == 32'(WORDS - 1);
    assign active      = r_s1_valid && r_enable && in_range;
    assign key_eq      = key_rd == word_w;

    always_comb begin
        n_match        = r_match;
        n_entry_valid  = r_entry_valid;
        n_miss_pending = r_miss_pending;
        n_hit_counter  = r_hit_counter;
        n_miss_counter = r_miss_counter;
        value_w        = word_w;
        n_write_back   = 1'b0;
        n_hit          = 1'b0;
        key_we         = 1'b0;
        delta_we       = 1'b0;
        snap_we        = 1'b0;
        if (active) begin
            unique case (mdc_pkg::t_action'(r_s1_action))
                mdc_pkg::ACT_KEY: begin
                    n_match = (is_first ? r_entry_valid : r_match) && key_eq;
                    key_we  = 1'b1;
                    if (is_last) begin
                        if (n_match) begin
                            n_hit_counter = r_hit_counter + 32'd1;
                            n_hit         = 1'b1;
                        end else begin
                            n_miss_counter = r_miss_counter + 32'd1;
                            n_entry_valid  = 1'b0;
                            n_miss_pending = 1'b1;
                        end
                    end
                end
                mdc_pkg::ACT_ACC_ENTRY: begin
                    if (r_match) begin
                        value_w      = word_w + delta_rd;
                        n_write_back = 1'b1;
                        n_hit        = 1'b1;
                    end else if (r_miss_pending) begin
                        snap_we = 1'b1;
                    end
                end
                mdc_pkg::ACT_ACC_RETURN: begin
                    if (r_miss_pending) begin
                        delta_we = 1'b1;
                        if (is_last) begin
                            n_entry_valid  = 1'b1;
                            n_miss_pending = 1'b0;
                            n_match        = 1'b0;
                        end
                    end
                end
                default: begin
                    // unused code: pass through
                end
            endcase
        end
        n_value_out = 32'(value_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match        <= 1'b0;
            r_entry_valid  <= 1'b0;
            r_miss_pending <= 1'b0;
            r_hit_counter  <= 32'd0;
            r_miss_counter <= 32'd0;
            r_out_valid    <= 1'b0;
            r_write_back   <= 1'b0;
            r_hit          <= 1'b0;
        end else begin
            r_match        <= n_match;
            r_entry_valid  <= n_entry_valid;
            r_miss_pending <= n_miss_pending;
            r_hit_counter  <= n_hit_counter;
            r_miss_counter <= n_miss_counter;
            r_out_valid    <= r_s1_valid;
            r_write_back   <= n_write_back;
            r_hit          <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value_out <= n_value_out;
    end

    assign o_valid      = r_out_valid;
    assign o_value_out  = r_value_out;
    assign o_write_back = r_write_back;
    assign o_hit        = r_hit;
    assign o_hit_count  = r_hit_counter;
    assign o_miss_count = r_miss_counter;

endmodule

FILE: rtl/core/mdc_checker.sv
// ----------------------------------------------------------------------------
// mdc_checker
// Port-level checks on the memoization delta cache, bound to its top level.
// ----------------------------------------------------------------------------
`include "memo_delta_cache_macros.svh"

module mdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_write_back,
    input logic        o_hit,
    input logic [31:0] o_hit_count,
    input logic [31:0] o_miss_count
);

    // a write-back only comes with a hit result
    `MDC_ASSERT_IMPL(a_wb_is_hit, o_write_back, o_hit && o_valid, "write-back without hit result")

    // every accepted request strobes its result, through the stage-1 and result registers
    `MDC_ASSERT_NEXT(a_result_latency, start && !busy, ##1 o_valid, "request lost")

    // counters move only together with a result
    `MDC_ASSERT_IMPL(a_count_with_result, $past(i_rst_n) && (o_hit_count != $past(o_hit_count) || o_miss_count != $past(o_miss_count)), o_valid, "counter moved without result")

    // counters step by at most one per request
    `MDC_ASSERT_IMPL(a_hit_step, $past(i_rst_n), o_hit_count == $past(o_hit_count) || o_hit_count == $past(o_hit_count) + 32'd1, "hit count jumped")
    `MDC_ASSERT_IMPL(a_miss_step, $past(i_rst_n), o_miss_count == $past(o_miss_count) || o_miss_count == $past(o_miss_count) + 32'd1, "miss count jumped")

endmodule

bind memo_delta_cache mdc_checker u_mdc_checker (.*);
